// ===== hw/rtl/gti_pkg.sv =====
// Shared widths, register indexes, codes and handshake structs for the gyro tare and integrate block.
package gti_pkg;

	// Default timestamp width in bits.
	localparam int TIME_WIDTH_DEF = 32;

	// Field and state widths.
	localparam int AXIS_W      = 16;
	localparam int BYTE_W      = 8;
	localparam int SUM_W       = 29;
	localparam int DIV_W       = SUM_W;
	localparam int CNT_W       = 12;
	localparam int BLK_W       = 8;
	localparam int SCALE_W     = 16;
	localparam int ADJ_W       = SUM_W + 1;
	localparam int MAG_W       = ADJ_W + SCALE_W;
	localparam int ACC_W       = 64;
	localparam int SAT_W       = ACC_W - 1;
	localparam int OUT_W       = 32;
	localparam int ANGLE_SHIFT = 24;
	localparam int AXES        = 3;
	localparam int AXIS_IDX_W  = 2;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_TARE_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_SCALE  = 2'd2;

	// Register reset values.
	localparam logic [CNT_W-1:0]   TARE_COUNT_RST  = 12'd1000;
	localparam logic [BLK_W-1:0]   BLOCK_COUNT_RST = 8'd10;
	localparam logic [SCALE_W-1:0] RATE_SCALE_RST  = 16'd8523;

	// Operation codes of the shared arithmetic unit.
	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	// Result kinds.
	localparam logic KIND_BIAS  = 1'b0;
	localparam logic KIND_ANGLE = 1'b1;

	// Request from the sequencer to the arithmetic unit.
	typedef struct packed {
		logic start;
		logic op;
	} gti_req_t;

	// Status from the arithmetic unit back to the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} gti_resp_t;

endpackage

// ===== hw/rtl/gti_if.sv =====
// Channel interfaces for samples, results and configuration writes.
interface gti_sample_if import gti_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic [BYTE_W-1:0]     x_high;
	logic [BYTE_W-1:0]     x_low;
	logic [BYTE_W-1:0]     y_high;
	logic [BYTE_W-1:0]     y_low;
	logic [BYTE_W-1:0]     z_high;
	logic [BYTE_W-1:0]     z_low;
	logic [TIME_WIDTH-1:0] time_us;

	modport source (
		output valid, x_high, x_low, y_high, y_low, z_high, z_low, time_us,
		input  ready
	);
	modport sink (
		input  valid, x_high, x_low, y_high, y_low, z_high, z_low, time_us,
		output ready
	);
endinterface

interface gti_result_if import gti_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    kind;
	logic signed [OUT_W-1:0] out_x;
	logic signed [OUT_W-1:0] out_y;
	logic signed [OUT_W-1:0] out_z;

	modport source (
		output valid, kind, out_x, out_y, out_z,
		input  ready
	);
	modport sink (
		input  valid, kind, out_x, out_y, out_z,
		output ready
	);
endinterface

interface gti_cfg_if import gti_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// ===== hw/rtl/gti_iter_unit.sv =====
// Shared iterative unit: restoring divider and shift-add multiplier on one adder.
module gti_iter_unit import gti_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gti_req_t                    req,
	input  logic [MAG_W-1:0]            mul_a,
	input  logic [TIME_WIDTH-1:0]       mul_b,
	input  logic [DIV_W-1:0]            div_n,
	input  logic [CNT_W-1:0]            div_d,
	output gti_resp_t                   resp,
	output logic [MAG_W+TIME_WIDTH-1:0] prod,
	output logic [DIV_W-1:0]            quot
);

	localparam int LO_W   = (TIME_WIDTH > DIV_W) ? TIME_WIDTH : DIV_W;
	localparam int STEP_W = $clog2(LO_W + 1);
	localparam int ADD_W  = MAG_W + 1;

	logic [MAG_W-1:0]  a_q;
	logic [ADD_W-1:0]  hi_q;
	logic [LO_W-1:0]   lo_q;
	logic              op_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [CNT_W:0]    rem_sh;
	logic [ADD_W-1:0]  add_x;
	logic [ADD_W-1:0]  add_y;
	logic [ADD_W-1:0]  add_sum;
	logic              add_ci;
	logic              q_bit;
	logic [ADD_W-1:0]  hi_nxt;
	logic [LO_W-1:0]   lo_nxt;

	// One adder serves both operations: a trial subtract of the divisor, or an
	// add of the multiplicand when the current multiplier bit is set.
	always_comb begin
		rem_sh = {hi_q[CNT_W-1:0], lo_q[DIV_W-1]};
		if (op_q == OP_DIV) begin
			add_x  = ADD_W'(rem_sh);
			add_y  = ~ADD_W'(a_q[CNT_W-1:0]);
			add_ci = 1'b1;
		end else begin
			add_x  = {1'b0, hi_q[MAG_W-1:0]};
			add_y  = lo_q[0] ? {1'b0, a_q} : '0;
			add_ci = 1'b0;
		end
		add_sum = add_x + add_y + ADD_W'(add_ci);
		q_bit   = ~add_sum[ADD_W-1];

		hi_nxt = hi_q;
		lo_nxt = lo_q;
		if (op_q == OP_DIV) begin
			hi_nxt               = q_bit ? add_sum : ADD_W'(rem_sh);
			lo_nxt[DIV_W-1:0]    = {lo_q[DIV_W-2:0], q_bit};
		end else begin
			hi_nxt               = {1'b0, add_sum[ADD_W-1:1]};
			lo_nxt[TIME_WIDTH-1:0] = {add_sum[0], lo_q[TIME_WIDTH-1:1]};
		end
	end

	// Step counter and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= (req.op == OP_DIV) ? STEP_W'(DIV_W) : STEP_W'(TIME_WIDTH);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial result registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q <= req.op;
			hi_q <= '0;
			if (req.op == OP_DIV) begin
				a_q  <= MAG_W'(div_d);
				lo_q <= LO_W'(div_n);
			end else begin
				a_q  <= mul_a;
				lo_q <= LO_W'(mul_b);
			end
		end else if (busy_q) begin
			hi_q <= hi_nxt;
			lo_q <= lo_nxt;
		end
	end

	assign resp.busy = busy_q;
	assign resp.done = done_q;
	assign prod      = {hi_q[MAG_W-1:0], lo_q[TIME_WIDTH-1:0]};
	assign quot      = lo_q[DIV_W-1:0];

endmodule

// ===== hw/rtl/gyro_tare_and_integrate.sv =====
// Top level: gyro bias tare followed by block averaging and saturating angle integration.
// A sample that does not close a phase is added to the running sums and gives no result.
// A sample that closes the tare phase runs three 29-step divisions on the shared
// divider/multiplier unit.
// A sample that closes an integration block runs, per axis, one division, one scale
// multiply and a TIME_WIDTH-step multiply.
// Reset restores the register defaults, starts the tare phase and clears all sums.
module gyro_tare_and_integrate import gti_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	gti_cfg_if.sink      cfg,
	gti_sample_if.sink   sample,
	gti_result_if.source result
);

	localparam int PROD_W = MAG_W + TIME_WIDTH;
	localparam int PEXT_W = (PROD_W > ACC_W) ? PROD_W : ACC_W;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_DIV_W = 3'd2;
	localparam logic [2:0] ST_MAG   = 3'd3;
	localparam logic [2:0] ST_MUL   = 3'd4;
	localparam logic [2:0] ST_MUL_W = 3'd5;
	localparam logic [2:0] ST_ACC   = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	logic [2:0]              state_q;
	logic [CNT_W-1:0]        tare_q;
	logic [BLK_W-1:0]        block_q;
	logic [SCALE_W-1:0]      scale_q;
	logic                    in_tare_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [SUM_W-1:0] sum_q [AXES];
	logic signed [SUM_W-1:0] bias_q [AXES];
	logic signed [ACC_W-1:0] acc_q [AXES];
	logic [TIME_WIDTH-1:0]   prev_q;
	logic [TIME_WIDTH-1:0]   elapsed_q;
	logic [CNT_W-1:0]        lim_q;
	logic [AXIS_IDX_W-1:0]   axis_q;
	logic                    adj_neg_q;
	logic [ADJ_W-1:0]        adj_mag_q;
	logic [MAG_W-1:0]        mag_q;
	logic [SAT_W-1:0]        prod_q;

	logic                    out_valid_q;
	logic                    out_kind_q;
	logic signed [OUT_W-1:0] out_q [AXES];

	logic signed [SUM_W-1:0] smp [AXES];
	logic signed [SUM_W-1:0] sum_new [AXES];
	logic [CNT_W-1:0]        lim_raw;
	logic [CNT_W-1:0]        lim;
	logic                    phase_end;
	logic                    accept;
	logic                    out_load;
	logic [TIME_WIDTH-1:0]   now;

	logic signed [SUM_W-1:0] sel_sum;
	logic signed [SUM_W-1:0] sel_bias;
	logic signed [ACC_W-1:0] sel_acc;
	logic [DIV_W-1:0]        div_n;
	logic signed [SUM_W-1:0] mean;
	logic signed [ADJ_W-1:0] adj;
	logic [PEXT_W-1:0]       prod_ext;
	logic                    prod_ovf;
	logic signed [ACC_W-1:0] p64;
	logic signed [ACC_W-1:0] acc_add;
	logic signed [ACC_W-1:0] acc_sub;
	logic signed [ACC_W-1:0] acc_nxt;
	logic signed [OUT_W-1:0] angle [AXES];

	gti_req_t                unit_req;
	gti_resp_t               unit_resp;
	logic [PROD_W-1:0]       unit_prod;
	logic [DIV_W-1:0]        unit_quot;

	// Shared divider and multiplier.
	gti_iter_unit #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (unit_req),
		.mul_a  (mag_q),
		.mul_b  (elapsed_q),
		.div_n  (div_n),
		.div_d  (lim_q),
		.resp   (unit_resp),
		.prod   (unit_prod),
		.quot   (unit_quot)
	);

	assign unit_req.start = (state_q == ST_DIV) || (state_q == ST_MUL);
	assign unit_req.op    = (state_q == ST_DIV) ? OP_DIV : OP_MUL;

	// Sample decode, running sums and the phase end test.
	always_comb begin
		smp[0] = SUM_W'(signed'({sample.x_high, sample.x_low}));
		smp[1] = SUM_W'(signed'({sample.y_high, sample.y_low}));
		smp[2] = SUM_W'(signed'({sample.z_high, sample.z_low}));
		for (int i = 0; i < AXES; i++) begin
			sum_new[i] = sum_q[i] + smp[i];
		end
		lim_raw   = in_tare_q ? tare_q : CNT_W'(block_q);
		lim       = (lim_raw == '0) ? CNT_W'(1) : lim_raw;
		phase_end = ({1'b0, cnt_q} + (CNT_W + 1)'(1)) >= {1'b0, lim};
	end

	assign now          = sample.time_us[TIME_WIDTH-1:0];
	assign sample.ready = (state_q == ST_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign cfg.ready    = 1'b1;

	// Per-axis datapath for the axis under work.
	always_comb begin
		sel_sum  = sum_q[axis_q];
		sel_bias = bias_q[axis_q];
		sel_acc  = acc_q[axis_q];
		div_n    = sel_sum[SUM_W-1] ? DIV_W'(-sel_sum) : DIV_W'(sel_sum);
		mean     = sel_sum[SUM_W-1] ? -signed'(unit_quot) : signed'(unit_quot);
		adj      = ADJ_W'(mean) - ADJ_W'(sel_bias);

		prod_ext = PEXT_W'(unit_prod);
		prod_ovf = |prod_ext[PEXT_W-1:SAT_W];

		p64     = signed'({1'b0, prod_q});
		acc_add = sel_acc + p64;
		acc_sub = sel_acc - p64;
		if (!adj_neg_q) begin
			acc_nxt = (!sel_acc[ACC_W-1] && acc_add[ACC_W-1]) ?
				{1'b0, {(ACC_W-1){1'b1}}} : acc_add;
		end else begin
			acc_nxt = (sel_acc[ACC_W-1] && !acc_sub[ACC_W-1]) ?
				{1'b1, {(ACC_W-1){1'b0}}} : acc_sub;
		end
	end

	// Angle output: floor shift to Q16.16, then clamp to 32 bits.
	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			if (acc_q[i][ACC_W-1:ANGLE_SHIFT+OUT_W-1] ==
				{(ACC_W-ANGLE_SHIFT-OUT_W+1){acc_q[i][ACC_W-1]}}) begin
				angle[i] = acc_q[i][ANGLE_SHIFT+OUT_W-1:ANGLE_SHIFT];
			end else if (acc_q[i][ACC_W-1]) begin
				angle[i] = {1'b1, {(OUT_W-1){1'b0}}};
			end else begin
				angle[i] = {1'b0, {(OUT_W-1){1'b1}}};
			end
		end
	end

	assign out_load = (state_q == ST_FIN) && (!out_valid_q || result.ready);

	// Sequencer, configuration registers and block state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			tare_q    <= TARE_COUNT_RST;
			block_q   <= BLOCK_COUNT_RST;
			scale_q   <= RATE_SCALE_RST;
			in_tare_q <= 1'b1;
			cnt_q     <= '0;
			prev_q    <= '0;
			axis_q    <= '0;
			for (int i = 0; i < AXES; i++) begin
				sum_q[i]  <= '0;
				bias_q[i] <= '0;
				acc_q[i]  <= '0;
			end
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					CFG_TARE_COUNT:  tare_q  <= cfg.data[CNT_W-1:0];
					CFG_BLOCK_COUNT: block_q <= cfg.data[BLK_W-1:0];
					CFG_RATE_SCALE:  scale_q <= cfg.data[SCALE_W-1:0];
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						for (int i = 0; i < AXES; i++) begin
							sum_q[i] <= sum_new[i];
						end
						if (phase_end) begin
							prev_q  <= now;
							axis_q  <= '0;
							state_q <= ST_DIV;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_DIV: begin
					state_q <= ST_DIV_W;
				end
				ST_DIV_W: begin
					if (unit_resp.done) begin
						if (in_tare_q) begin
							bias_q[axis_q] <= mean;
							if (axis_q == AXIS_IDX_W'(AXES - 1)) begin
								state_q <= ST_FIN;
							end else begin
								axis_q  <= axis_q + 1'b1;
								state_q <= ST_DIV;
							end
						end else begin
							state_q <= ST_MAG;
						end
					end
				end
				ST_MAG: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_MUL_W;
				end
				ST_MUL_W: begin
					if (unit_resp.done) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					acc_q[axis_q] <= acc_nxt;
					if (axis_q == AXIS_IDX_W'(AXES - 1)) begin
						state_q <= ST_FIN;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						in_tare_q <= 1'b0;
						cnt_q     <= '0;
						axis_q    <= '0;
						for (int i = 0; i < AXES; i++) begin
							sum_q[i] <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers of the per-axis computation.
	always_ff @(posedge clk) begin
		if (accept && phase_end) begin
			lim_q     <= lim;
			elapsed_q <= now - prev_q;
		end
		if (state_q == ST_DIV_W && unit_resp.done) begin
			adj_neg_q <= adj[ADJ_W-1];
			adj_mag_q <= adj[ADJ_W-1] ? ADJ_W'(-adj) : ADJ_W'(adj);
		end
		if (state_q == ST_MAG) begin
			mag_q <= MAG_W'(adj_mag_q * scale_q);
		end
		if (state_q == ST_MUL_W && unit_resp.done) begin
			prod_q <= prod_ovf ? {SAT_W{1'b1}} : prod_ext[SAT_W-1:0];
		end
	end

	// Output register: holds one result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q <= in_tare_q ? KIND_BIAS : KIND_ANGLE;
			for (int i = 0; i < AXES; i++) begin
				out_q[i] <= in_tare_q ? OUT_W'(bias_q[i]) : angle[i];
			end
		end
	end

	assign result.valid = out_valid_q;
	assign result.kind  = out_kind_q;
	assign result.out_x = out_q[0];
	assign result.out_y = out_q[1];
	assign result.out_z = out_q[2];

	// The unit is never busy while a new sample may be taken.
	a_ready_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sample.ready |-> !unit_resp.busy)
		else $error("sample ready while arithmetic unit busy");

	// A unit completion only arrives while the sequencer waits for it.
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		unit_resp.done |-> (state_q == ST_DIV_W || state_q == ST_MUL_W))
		else $error("arithmetic unit completion outside a wait state");

	// A phase-closing sample starts the first division at once.
	a_phase_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_end) |=> (state_q == ST_DIV && axis_q == '0))
		else $error("phase end did not start the division sequence");

	// Emitting a result leaves the tare phase and restarts the sample count.
	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (cnt_q == '0 && !in_tare_q && state_q == ST_IDLE))
		else $error("phase state not cleared after result load");

	// The axis index rests at zero between items.
	a_axis_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (axis_q == '0))
		else $error("axis index not cleared while idle");

endmodule
